### sv/spav_pkg.sv
`timescale 1ns / 1ps
// shared types and widths for the softened point-attractor velocity kick
// used by every cell module and by the top level; no dependencies
package spav_pkg;

	localparam int VEL_W   = 32;
	localparam int REG_W   = 31;
	localparam int NAX     = 3;
	localparam int MAG_W   = 33;
	localparam int SQR_W   = 66;
	localparam int S_W     = 66;
	localparam int ROOT_W  = 33;
	localparam int SREM_W  = ROOT_W + 3;
	localparam int PGM_W   = 2 * REG_W;
	localparam int KL_W    = 32 + REG_W;
	localparam int KH_W    = PGM_W - 32 + REG_W;
	localparam int K_W     = 93;
	localparam int D_W     = 66;
	localparam int CHUNK   = 32;
	localparam int MAC_A_W = 96;
	localparam int MAC_B_W = 33;
	localparam int PROD_W  = CHUNK + MAC_B_W;
	localparam int ACC_W   = MAC_A_W + MAC_B_W;
	localparam int NLANE   = 4;
	localparam int DEN_W   = 99;
	localparam int NUM_W   = 125;
	localparam int Q_W     = 34;
	localparam int SQ_STEPS  = S_W / 2;
	localparam int MAC_STEPS = MAC_A_W / CHUNK;
	localparam int DIV_STEPS = Q_W;

	// configuration register indexes
	localparam logic [1:0] REG_GRAV = 2'd0;
	localparam logic [1:0] REG_MASS = 2'd1;
	localparam logic [1:0] REG_SOFT = 2'd2;
	localparam logic [1:0] REG_MIND = 2'd3;

	// everything that travels along the pipe with one particle
	typedef struct packed {
		logic [NAX-1:0][VEL_W-1:0]   vel;
		logic [NAX-1:0]              neg;
		logic [NAX-1:0][MAG_W-1:0]   mag;
		logic [REG_W-1:0]            dt;
		logic [NAX-1:0][SQR_W-1:0]   sqr;
		logic [KL_W-1:0]             kl;
		logic [KH_W-1:0]             kh;
		logic [K_W-1:0]              k;
		logic [S_W-1:0]              s;
		logic [S_W-1:0]              s_sh;
		logic [SREM_W-1:0]           s_rem;
		logic [ROOT_W-1:0]           root;
		logic                        skip;
		logic [NLANE-1:0][MAC_A_W-1:0] mac_a;
		logic [NLANE-1:0][MAC_B_W-1:0] mac_b;
		logic [NLANE-1:0][ACC_W-1:0]   mac_acc;
		logic [DEN_W-1:0]            den;
		logic [NAX-1:0]              ovf;
		logic [NAX-1:0][DEN_W-1:0]   rem;
		logic [NAX-1:0][Q_W-1:0]     low;
		logic [NAX-1:0][Q_W-1:0]     quo;
	} pipe_t;

endpackage

### sv/spav_sqrt_cell.sv
`timescale 1ns / 1ps
// one digit step of the integer square root: takes two bits of the sum of squares
// depends on spav_pkg
module spav_sqrt_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_in,
	input  spav_pkg::pipe_t item_in,
	output logic            vld_s1,
	output spav_pkg::pipe_t item_s1
);
	import spav_pkg::*;

	logic [SREM_W-1:0] rem_sh;
	logic [SREM_W-1:0] trial;
	logic              ge;
	pipe_t             nxt;

	// shift in two bits, try root*4+1
	always_comb begin
		rem_sh = {item_in.s_rem[SREM_W-3:0], item_in.s_sh[S_W-1 -: 2]};
		trial  = {1'b0, item_in.root, 2'b01};
		ge     = (rem_sh >= trial);
		nxt        = item_in;
		nxt.s_sh   = {item_in.s_sh[S_W-3:0], 2'b00};
		nxt.s_rem  = ge ? (rem_sh - trial) : rem_sh;
		nxt.root   = {item_in.root[ROOT_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= nxt;
		end
	end

endmodule

### sv/spav_mac_cell.sv
`timescale 1ns / 1ps
// one chunk step of the wide products: acc = acc*2^32 + top chunk * b, four lanes
// depends on spav_pkg
module spav_mac_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_in,
	input  spav_pkg::pipe_t item_in,
	output logic            vld_s1,
	output spav_pkg::pipe_t item_s1
);
	import spav_pkg::*;

	logic [PROD_W-1:0] prod [NLANE];
	pipe_t             nxt;

	// most significant chunk first, operand shifts up one chunk per cell
	always_comb begin
		nxt = item_in;
		for (int l = 0; l < NLANE; l++) begin
			prod[l] = item_in.mac_a[l][MAC_A_W-1 -: CHUNK] * item_in.mac_b[l];
			nxt.mac_acc[l] = {item_in.mac_acc[l][ACC_W-CHUNK-1:0], {CHUNK{1'b0}}}
				+ {{(ACC_W-PROD_W){1'b0}}, prod[l]};
			nxt.mac_a[l] = {item_in.mac_a[l][MAC_A_W-CHUNK-1:0], {CHUNK{1'b0}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= nxt;
		end
	end

endmodule

### sv/spav_div_cell.sv
`timescale 1ns / 1ps
// one restoring division step per axis: one quotient bit per cell
// depends on spav_pkg
module spav_div_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_in,
	input  spav_pkg::pipe_t item_in,
	output logic            vld_s1,
	output spav_pkg::pipe_t item_s1
);
	import spav_pkg::*;

	logic [DEN_W:0] rem_sh [NAX];
	logic [DEN_W:0] diff   [NAX];
	logic [NAX-1:0] ge;
	pipe_t          nxt;

	// bring down the next numerator bit and compare against the denominator
	always_comb begin
		nxt = item_in;
		for (int a = 0; a < NAX; a++) begin
			rem_sh[a] = {item_in.rem[a], item_in.low[a][Q_W-1]};
			diff[a]   = rem_sh[a] - {1'b0, item_in.den};
			ge[a]     = (rem_sh[a] >= {1'b0, item_in.den});
			nxt.rem[a] = ge[a] ? diff[a][DEN_W-1:0] : rem_sh[a][DEN_W-1:0];
			nxt.low[a] = {item_in.low[a][Q_W-2:0], 1'b0};
			nxt.quo[a] = {item_in.quo[a][Q_W-2:0], ge[a]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= nxt;
		end
	end

endmodule

### sv/softened_point_attractor_velocity.sv
`timescale 1ns / 1ps
// softened point-attractor velocity kick, one particle per cycle unless the output is stalled
// stages in order: 3 setup stages, 33 root cells, 1 stage, 3 product cells,
// 1 stage, 34 divide cells, 1 output register; throughput one beat per cycle while not stalled;
// the whole pipe freezes while a held output beat is stalled
// reset clears all valid bits and loads the register reset values
module softened_point_attractor_velocity #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [31:0] vel_x,
	input  logic [31:0] vel_y,
	input  logic [31:0] vel_z,
	input  logic [31:0] attractor_x,
	input  logic [31:0] attractor_y,
	input  logic [31:0] attractor_z,
	input  logic [30:0] time_step,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] new_vel_x,
	output logic [31:0] new_vel_y,
	output logic [31:0] new_vel_z,
	output logic        skipped,
	output logic        saturated,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data
);
	import spav_pkg::*;

	localparam longint unsigned ONE_L  = 64'd1 << FRAC_BITS;
	localparam longint unsigned SOFT_L = (ONE_L + 64'd5) / 64'd10;
	localparam longint unsigned MIND_L = (ONE_L + 64'd500) / 64'd1000;
	localparam logic [REG_W-1:0] ONE_RST  = REG_W'(ONE_L);
	localparam logic [REG_W-1:0] SOFT_RST = REG_W'(SOFT_L);
	localparam logic [REG_W-1:0] MIND_RST = REG_W'(MIND_L);
	localparam logic [PGM_W-1:0] GM_RST   = PGM_W'(ONE_L * ONE_L);
	localparam logic [PGM_W-1:0] SOFT2_RST = PGM_W'(SOFT_L * SOFT_L);
	localparam logic [Q_W-1:0]   DV_MAX   = {1'b1, {(Q_W-1){1'b0}}};
	localparam logic signed [VEL_W+3:0] POS_LIM = 36'sd2147483647;
	localparam logic signed [VEL_W+3:0] NEG_LIM = -36'sd2147483648;

	logic             en;
	logic [REG_W-1:0] grav_q, mass_q, soft_q, mind_q;
	logic [PGM_W-1:0] gm_q, soft2_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= ONE_RST;
			mass_q <= ONE_RST;
			soft_q <= SOFT_RST;
			mind_q <= MIND_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_GRAV: grav_q <= cfg_data;
				REG_MASS: mass_q <= cfg_data;
				REG_SOFT: soft_q <= cfg_data;
				REG_MIND: mind_q <= cfg_data;
			endcase
		end
	end

	// products of configuration values, registered from the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gm_q    <= GM_RST;
			soft2_q <= SOFT2_RST;
		end else begin
			gm_q    <= grav_q * mass_q;
			soft2_q <= soft_q * soft_q;
		end
	end

	// global advance: hold everything while the output beat is stalled
	assign en       = !out_valid || !out_stall;
	assign in_stall = !en;

	// stage 1: offsets, magnitudes and signs
	logic [VEL_W-1:0]  pos_a [NAX];
	logic [VEL_W-1:0]  att_a [NAX];
	logic [VEL_W-1:0]  vel_a [NAX];
	logic signed [MAG_W-1:0] dif [NAX];
	pipe_t nxt1;
	pipe_t item_s1;
	logic  vld_s1;

	always_comb begin
		pos_a[0] = pos_x; pos_a[1] = pos_y; pos_a[2] = pos_z;
		att_a[0] = attractor_x; att_a[1] = attractor_y; att_a[2] = attractor_z;
		vel_a[0] = vel_x; vel_a[1] = vel_y; vel_a[2] = vel_z;
		nxt1 = '0;
		nxt1.dt = time_step;
		for (int a = 0; a < NAX; a++) begin
			dif[a] = $signed({att_a[a][VEL_W-1], att_a[a]})
				- $signed({pos_a[a][VEL_W-1], pos_a[a]});
			nxt1.vel[a] = vel_a[a];
			nxt1.neg[a] = dif[a][MAG_W-1];
			nxt1.mag[a] = dif[a][MAG_W-1] ? (-dif[a]) : dif[a];
		end
	end

	// stage 2: squares and the two halves of the kick constant
	pipe_t nxt2;
	pipe_t item_s2;
	logic  vld_s2;

	always_comb begin
		nxt2 = item_s1;
		for (int a = 0; a < NAX; a++) begin
			nxt2.sqr[a] = item_s1.mag[a] * item_s1.mag[a];
		end
		nxt2.kl = gm_q[31:0] * item_s1.dt;
		nxt2.kh = gm_q[PGM_W-1:32] * item_s1.dt;
	end

	// stage 3: sum of squares and full kick constant, seed the root chain
	pipe_t nxt3;
	pipe_t item_s3;
	logic  vld_s3;

	always_comb begin
		nxt3 = item_s2;
		nxt3.s = item_s2.sqr[0] + item_s2.sqr[1] + item_s2.sqr[2];
		nxt3.k = {{(K_W-KL_W){1'b0}}, item_s2.kl}
			+ {item_s2.kh, 32'd0};
		nxt3.s_sh  = nxt3.s;
		nxt3.s_rem = '0;
		nxt3.root  = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1 <= nxt1;
			item_s2 <= nxt2;
			item_s3 <= nxt3;
		end
	end

	// root chain
	pipe_t sq_item [SQ_STEPS+1];
	logic  sq_vld  [SQ_STEPS+1];
	assign sq_item[0] = item_s3;
	assign sq_vld[0]  = vld_s3;

	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
		spav_sqrt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_in  (sq_vld[g]),
			.item_in (sq_item[g]),
			.vld_s1  (sq_vld[g+1]),
			.item_s1 (sq_item[g+1])
		);
	end

	// stage 4: near test, softened denominator, seed the product chain
	pipe_t nxt4;
	pipe_t item_s4;
	logic  vld_s4;
	logic [D_W-1:0] dsum;

	always_comb begin
		nxt4 = sq_item[SQ_STEPS];
		dsum = sq_item[SQ_STEPS].s + {{(D_W-PGM_W){1'b0}}, soft2_q};
		nxt4.skip = (sq_item[SQ_STEPS].root <= {{(ROOT_W-REG_W){1'b0}}, mind_q});
		nxt4.mac_a[0] = {{(MAC_A_W-D_W){1'b0}}, dsum};
		nxt4.mac_b[0] = sq_item[SQ_STEPS].root;
		for (int a = 0; a < NAX; a++) begin
			nxt4.mac_a[a+1] = {{(MAC_A_W-K_W){1'b0}}, sq_item[SQ_STEPS].k};
			nxt4.mac_b[a+1] = sq_item[SQ_STEPS].mag[a];
		end
		nxt4.mac_acc = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= sq_vld[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s4 <= nxt4;
		end
	end

	// product chain
	pipe_t mac_item [MAC_STEPS+1];
	logic  mac_vld  [MAC_STEPS+1];
	assign mac_item[0] = item_s4;
	assign mac_vld[0]  = vld_s4;

	for (genvar g = 0; g < MAC_STEPS; g++) begin : g_mac
		spav_mac_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_in  (mac_vld[g]),
			.item_in (mac_item[g]),
			.vld_s1  (mac_vld[g+1]),
			.item_s1 (mac_item[g+1])
		);
	end

	// stage 5: quotient range check, seed the divide chain
	pipe_t nxt5;
	pipe_t item_s5;
	logic  vld_s5;
	logic [NUM_W-1:0] num [NAX];

	always_comb begin
		nxt5 = mac_item[MAC_STEPS];
		nxt5.den = mac_item[MAC_STEPS].mac_acc[0][DEN_W-1:0];
		for (int a = 0; a < NAX; a++) begin
			num[a] = mac_item[MAC_STEPS].mac_acc[a+1][NUM_W-1:0];
			nxt5.ovf[a] = ({{(DEN_W+Q_W-NUM_W){1'b0}}, num[a]} >= {nxt5.den, {Q_W{1'b0}}});
			nxt5.rem[a] = {{(DEN_W-NUM_W+Q_W){1'b0}}, num[a][NUM_W-1:Q_W]};
			nxt5.low[a] = num[a][Q_W-1:0];
			nxt5.quo[a] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= mac_vld[MAC_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s5 <= nxt5;
		end
	end

	// divide chain
	pipe_t div_item [DIV_STEPS+1];
	logic  div_vld  [DIV_STEPS+1];
	assign div_item[0] = item_s5;
	assign div_vld[0]  = vld_s5;

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
		spav_div_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld_in  (div_vld[g]),
			.item_in (div_item[g]),
			.vld_s1  (div_vld[g+1]),
			.item_s1 (div_item[g+1])
		);
	end

	// final kick, saturation and pass-through for near particles
	pipe_t last;
	logic [Q_W-1:0]          dv  [NAX];
	logic signed [VEL_W+3:0] nv  [NAX];
	logic [VEL_W-1:0]        res [NAX];
	logic [NAX-1:0]          clamp;

	always_comb begin
		last = div_item[DIV_STEPS];
		for (int a = 0; a < NAX; a++) begin
			dv[a] = (last.ovf[a] || (last.quo[a] > DV_MAX)) ? DV_MAX : last.quo[a];
			nv[a] = last.neg[a]
				? $signed({{4{last.vel[a][VEL_W-1]}}, last.vel[a]}) - $signed({2'b00, dv[a]})
				: $signed({{4{last.vel[a][VEL_W-1]}}, last.vel[a]}) + $signed({2'b00, dv[a]});
			clamp[a] = 1'b0;
			res[a]   = nv[a][VEL_W-1:0];
			if (nv[a] > POS_LIM) begin
				res[a]   = POS_LIM[VEL_W-1:0];
				clamp[a] = 1'b1;
			end else if (nv[a] < NEG_LIM) begin
				res[a]   = NEG_LIM[VEL_W-1:0];
				clamp[a] = 1'b1;
			end
			if (last.skip) begin
				res[a]   = last.vel[a];
				clamp[a] = 1'b0;
			end
		end
	end

	// output register
	logic             out_vld_q;
	logic [VEL_W-1:0] nvel_q [NAX];
	logic             skip_q, sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= div_vld[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NAX; a++) begin
				nvel_q[a] <= res[a];
			end
			skip_q <= last.skip;
			sat_q  <= |clamp;
		end
	end

	assign out_valid = out_vld_q;
	assign new_vel_x = nvel_q[0];
	assign new_vel_y = nvel_q[1];
	assign new_vel_z = nvel_q[2];
	assign skipped   = skip_q;
	assign saturated = sat_q;

	// checks
	a_skip_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && skipped |-> !saturated)
		else $error("skipped beat reports saturation");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s1)
		else $error("accepted beat missing from first stage");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(vld_s5) && $stable(vld_s4))
		else $error("pipe moved while output stalled");

endmodule
